@@ design/mch_pkg.sv @@
package mch_pkg;

  localparam int ACC_FRAC = 20;
  localparam int ACC_W = 31;
  localparam int ANG_W = 29;
  localparam int CX_W = 36;
  localparam int AXIS_SHIFT = 16;
  localparam int TABLE_LEN = 24;

  localparam logic signed [ACC_W-1:0] DEG_0 = 31'sd0;
  localparam logic signed [ACC_W-1:0] DEG_90 = 31'sd94371840;
  localparam logic signed [ACC_W-1:0] DEG_180 = 31'sd188743680;
  localparam logic signed [ACC_W-1:0] DEG_270 = 31'sd283115520;
  localparam logic signed [ACC_W-1:0] DEG_360 = 31'sd377487360;

  localparam logic signed [ACC_W-1:0] ATAN_TAB [TABLE_LEN] = '{
    31'sd47185920, 31'sd27855475, 31'sd14718068, 31'sd7471121, 31'sd3750058,
    31'sd1876857, 31'sd938658, 31'sd469357, 31'sd234682, 31'sd117342,
    31'sd58671, 31'sd29335, 31'sd14668, 31'sd7334, 31'sd3667, 31'sd1833,
    31'sd917, 31'sd458, 31'sd229, 31'sd115, 31'sd57, 31'sd29, 31'sd14, 31'sd7
  };

  typedef enum logic [1:0] {
    CARD_NORTH = 2'd0,
    CARD_EAST  = 2'd1,
    CARD_SOUTH = 2'd2,
    CARD_WEST  = 2'd3
  } card_t;

  typedef struct packed {
    logic [7:0] x_high;
    logic [7:0] x_low;
    logic [7:0] z_high;
    logic [7:0] z_low;
    logic [7:0] y_high;
    logic [7:0] y_low;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] x_field;
    logic signed [15:0] y_field;
    logic signed [15:0] z_field;
    logic [15:0]        heading_angle;
    card_t              cardinal;
  } out_word_t;

  typedef struct packed {
    logic signed [15:0]     x_field;
    logic signed [15:0]     y_field;
    logic signed [15:0]     z_field;
    logic                   bypass;
    logic signed [CX_W-1:0] cx;
    logic signed [CX_W-1:0] cy;
    logic signed [ACC_W-1:0] acc;
  } cordic_t;

endpackage

@@ design/mch_if.sv @@
interface mch_in_if import mch_pkg::*; ();
  logic     valid;
  logic     ready;
  in_word_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface mch_out_if import mch_pkg::*; ();
  logic      valid;
  logic      ready;
  out_word_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

@@ design/mch_prep.sv @@
module mch_prep import mch_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     up_valid,
  input  in_word_t up_data,
  output logic     up_ready,
  output logic     down_valid,
  output cordic_t  down_data,
  input  logic     down_ready
);

  logic signed [15:0]     x_val;
  logic signed [15:0]     y_val;
  logic signed [CX_W-1:0] sx;
  logic signed [CX_W-1:0] sy;
  cordic_t                data_next;
  logic                   valid;
  cordic_t                data;

  assign x_val = {up_data.x_high, up_data.x_low};
  assign y_val = {up_data.y_high, up_data.y_low};
  assign sx = CX_W'(x_val) <<< AXIS_SHIFT;
  assign sy = CX_W'(y_val) <<< AXIS_SHIFT;

  always_comb begin
    data_next.x_field = x_val;
    data_next.y_field = y_val;
    data_next.z_field = {up_data.z_high, up_data.z_low};
    data_next.bypass = (x_val == 16'sd0) || (y_val == 16'sd0);
    data_next.cx = x_val[15] ? -sx : sx;
    data_next.cy = x_val[15] ? -sy : sy;
    priority if (y_val == 16'sd0) begin
      data_next.acc = x_val[15] ? DEG_180 : DEG_0;
    end else if (x_val == 16'sd0) begin
      data_next.acc = y_val[15] ? DEG_270 : DEG_90;
    end else begin
      data_next.acc = x_val[15] ? DEG_180 : DEG_0;
    end
  end

  assign up_ready = !valid || down_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data <= data_next;
    end
  end

  assign down_valid = valid;
  assign down_data = data;

endmodule

@@ design/mch_cordic_stage.sv @@
module mch_cordic_stage import mch_pkg::*; #(
  parameter int STEP = 0
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    up_valid,
  input  cordic_t up_data,
  output logic    up_ready,
  output logic    down_valid,
  output cordic_t down_data,
  input  logic    down_ready
);

  logic signed [CX_W-1:0] dx;
  logic signed [CX_W-1:0] dy;
  cordic_t                data_next;
  logic                   valid;
  cordic_t                data;

  assign dx = $signed(up_data.cy) >>> STEP;
  assign dy = $signed(up_data.cx) >>> STEP;

  always_comb begin
    data_next = up_data;
    if (!up_data.bypass) begin
      if (!up_data.cy[CX_W-1]) begin
        data_next.cx = up_data.cx + dx;
        data_next.cy = up_data.cy - dy;
        data_next.acc = up_data.acc + ATAN_TAB[STEP];
      end else begin
        data_next.cx = up_data.cx - dx;
        data_next.cy = up_data.cy + dy;
        data_next.acc = up_data.acc - ATAN_TAB[STEP];
      end
    end
  end

  assign up_ready = !valid || down_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data <= data_next;
    end
  end

  assign down_valid = valid;
  assign down_data = data;

`ifndef SYNTHESIS
  // An on-axis reading has its exact angle already and must not be rotated.
  a_bypass_holds_angle: assert property (@(posedge clk) disable iff (rst)
    (up_valid && up_ready && up_data.bypass) |=> (data.acc == $past(up_data.acc)))
    else $error("axis reading changed its angle in a rotation stage");
`endif

endmodule

@@ design/mch_finish.sv @@
module mch_finish import mch_pkg::*; #(
  parameter int ANGLE_FRAC_BITS = 7
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      up_valid,
  input  cordic_t   up_data,
  output logic      up_ready,
  output logic      down_valid,
  output out_word_t down_data,
  input  logic      down_ready
);

  localparam int SHIFT = ACC_FRAC - ANGLE_FRAC_BITS;
  localparam int H_W = ANG_W - SHIFT;
  localparam logic [H_W-1:0] LIM_45 = H_W'(45 << ANGLE_FRAC_BITS);
  localparam logic [H_W-1:0] LIM_135 = H_W'(135 << ANGLE_FRAC_BITS);
  localparam logic [H_W-1:0] LIM_225 = H_W'(225 << ANGLE_FRAC_BITS);
  localparam logic [H_W-1:0] LIM_315 = H_W'(315 << ANGLE_FRAC_BITS);

  logic signed [ACC_W-1:0] acc_clamp;
  logic signed [ACC_W-1:0] acc_wrap;
  logic [ANG_W-1:0]        angle;
  logic [H_W-1:0]          heading;
  out_word_t               data_next;
  logic                    valid;
  out_word_t               data;

  always_comb begin
    acc_clamp = up_data.acc;
    if (up_data.y_field > 16'sd0 && up_data.acc[ACC_W-1]) begin
      acc_clamp = DEG_0;
    end
    if (up_data.y_field < 16'sd0 && up_data.x_field > 16'sd0 && !up_data.acc[ACC_W-1]) begin
      acc_clamp = -31'sd1;
    end
    acc_wrap = acc_clamp[ACC_W-1] ? acc_clamp + DEG_360 : acc_clamp;
  end

  assign angle = ANG_W'(acc_wrap);
  assign heading = H_W'(angle >> SHIFT);

  always_comb begin
    data_next.x_field = up_data.x_field;
    data_next.y_field = up_data.y_field;
    data_next.z_field = up_data.z_field;
    data_next.heading_angle = 16'(heading);
    priority if (heading >= LIM_315 || heading < LIM_45) begin
      data_next.cardinal = CARD_NORTH;
    end else if (heading < LIM_135) begin
      data_next.cardinal = CARD_EAST;
    end else if (heading < LIM_225) begin
      data_next.cardinal = CARD_SOUTH;
    end else begin
      data_next.cardinal = CARD_WEST;
    end
  end

  assign up_ready = !valid || down_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data <= data_next;
    end
  end

  assign down_valid = valid;
  assign down_data = data;

`ifndef SYNTHESIS
  a_zero_vector: assert property (@(posedge clk) disable iff (rst)
    (valid && data.x_field == 16'sd0 && data.y_field == 16'sd0)
      |-> (data.heading_angle == 16'd0 && data.cardinal == CARD_NORTH))
    else $error("zero vector did not give heading zero");

  a_neg_x_axis: assert property (@(posedge clk) disable iff (rst)
    (valid && data.y_field == 16'sd0 && data.x_field < 16'sd0)
      |-> (data.heading_angle == 16'(180 << ANGLE_FRAC_BITS)
           && data.cardinal == CARD_SOUTH))
    else $error("negative X axis did not give 180 degrees");

  a_pos_y_axis: assert property (@(posedge clk) disable iff (rst)
    (valid && data.x_field == 16'sd0 && data.y_field > 16'sd0)
      |-> (data.heading_angle == 16'(90 << ANGLE_FRAC_BITS)
           && data.cardinal == CARD_EAST))
    else $error("positive Y axis did not give 90 degrees");
`endif

endmodule

@@ design/magnetometer_compass_heading_core.sv @@
// Compass heading from one raw magnetometer reading.
// The sample channel carries one word per reading: the high and low bytes of the X, Z
// and Y axes. The result channel returns one word per reading: the three signed axis
// values, the heading atan2(y, x) in 2^-ANGLE_FRAC_BITS degree units wrapped into
// 0 to under 360 degrees, and a cardinal code (North, East, South, West).
// Both channels use valid/ready; a word moves on a clock edge where both are high.
// An accepted sample word passes through registered stages in order: the prep stage
// assembles the axes and folds the vector into the right half plane, a stage per CORDIC
// micro-rotation rotates it, and the finish stage wraps the angle and picks the
// cardinal code. The rotation pipeline takes a new sample word every cycle while the
// result channel keeps taking words, so the sustained rate is one reading per cycle.
// Every stage has its own valid bit and its own ready, so while the result channel is
// stalled the pipeline keeps filling its empty stages and sample ready drops only once
// every stage holds a word. No word is dropped or repeated across a stall.
// A synchronous reset empties the pipeline; there is no other state to clear.
module magnetometer_compass_heading_core import mch_pkg::*; #(
  parameter int ANGLE_FRAC_BITS = 7,
  parameter int CORDIC_STEPS = 16
) (
  input logic       clk,
  input logic       rst,
  mch_in_if.sink    sample,
  mch_out_if.source result
);

  localparam int STEPS = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;

  logic    pipe_valid [STEPS+1];
  logic    pipe_ready [STEPS+1];
  cordic_t pipe_data [STEPS+1];

  mch_prep u_prep (
    .clk        (clk),
    .rst        (rst),
    .up_valid   (sample.valid),
    .up_data    (sample.data),
    .up_ready   (sample.ready),
    .down_valid (pipe_valid[0]),
    .down_data  (pipe_data[0]),
    .down_ready (pipe_ready[0])
  );

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    mch_cordic_stage #(
      .STEP (k)
    ) u_stage (
      .clk        (clk),
      .rst        (rst),
      .up_valid   (pipe_valid[k]),
      .up_data    (pipe_data[k]),
      .up_ready   (pipe_ready[k]),
      .down_valid (pipe_valid[k+1]),
      .down_data  (pipe_data[k+1]),
      .down_ready (pipe_ready[k+1])
    );
  end

  mch_finish #(
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
  ) u_finish (
    .clk        (clk),
    .rst        (rst),
    .up_valid   (pipe_valid[STEPS]),
    .up_data    (pipe_data[STEPS]),
    .up_ready   (pipe_ready[STEPS]),
    .down_valid (result.valid),
    .down_data  (result.data),
    .down_ready (result.ready)
  );

endmodule

@@ tb/sv/magnetometer_compass_heading_core_test.sv @@
module magnetometer_compass_heading_core_test;
  import mch_pkg::*;

  localparam int FRAC = 7;
  localparam int STEPS = 16;
  localparam longint ONE_DEG = 64'sd1048576;
  localparam int RANDOM_READINGS = 1800;

  logic clk;
  logic rst;

  mch_in_if  sample_ch();
  mch_out_if result_ch();

  magnetometer_compass_heading_core #(
    .ANGLE_FRAC_BITS(FRAC),
    .CORDIC_STEPS(STEPS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .sample(sample_ch),
    .result(result_ch)
  );

  in_word_t  readings_pending[$];
  out_word_t headings_due[$];
  int        words_sent;
  int        words_seen;
  int        mismatches;
  int        hold_left;

  // Angle of (x, y) in degrees scaled by 2^20, wrapped into 0 to under 360.
  function automatic longint heading_fixed(int x, int y);
    longint vx;
    longint vy;
    longint ang;
    longint step_x;
    longint step_y;
    if (y == 0) begin
      return (x < 0) ? 180 * ONE_DEG : 0;
    end
    if (x == 0) begin
      return (y > 0) ? 90 * ONE_DEG : 270 * ONE_DEG;
    end
    vx = longint'(x) * 65536;
    vy = longint'(y) * 65536;
    ang = 0;
    if (x < 0) begin
      vx = -vx;
      vy = -vy;
      ang = 180 * ONE_DEG;
    end
    for (int i = 0; i < STEPS && i < TABLE_LEN; i++) begin
      step_x = vy >>> i;
      step_y = vx >>> i;
      if (vy >= 0) begin
        vx = vx + step_x;
        vy = vy - step_y;
        ang = ang + longint'(ATAN_TAB[i]);
      end else begin
        vx = vx - step_x;
        vy = vy + step_y;
        ang = ang - longint'(ATAN_TAB[i]);
      end
    end
    if (y > 0 && ang < 0) begin
      ang = 0;
    end
    if (y < 0 && x > 0 && ang >= 0) begin
      ang = -1;
    end
    if (ang < 0) begin
      ang = ang + 360 * ONE_DEG;
    end
    return ang;
  endfunction

  function automatic out_word_t compass_of(in_word_t s);
    out_word_t w;
    longint    h;
    w.x_field = {s.x_high, s.x_low};
    w.y_field = {s.y_high, s.y_low};
    w.z_field = {s.z_high, s.z_low};
    h = heading_fixed(int'(w.x_field), int'(w.y_field)) >>> (ACC_FRAC - FRAC);
    w.heading_angle = h[15:0];
    if (h >= (longint'(315) << FRAC) || h < (longint'(45) << FRAC)) begin
      w.cardinal = CARD_NORTH;
    end else if (h < (longint'(135) << FRAC)) begin
      w.cardinal = CARD_EAST;
    end else if (h < (longint'(225) << FRAC)) begin
      w.cardinal = CARD_SOUTH;
    end else begin
      w.cardinal = CARD_WEST;
    end
    return w;
  endfunction

  function automatic in_word_t reading(int x, int y, int z);
    in_word_t s;
    logic [15:0] xb;
    logic [15:0] yb;
    logic [15:0] zb;
    xb = x[15:0];
    yb = y[15:0];
    zb = z[15:0];
    s.x_high = xb[15:8];
    s.x_low  = xb[7:0];
    s.y_high = yb[15:8];
    s.y_low  = yb[7:0];
    s.z_high = zb[15:8];
    s.z_low  = zb[7:0];
    return s;
  endfunction

  task automatic check_word(out_word_t got);
    out_word_t want;
    if (headings_due.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("unexpected result word x=%0d y=%0d z=%0d heading=%0d cardinal=%0d",
                 got.x_field, got.y_field, got.z_field, got.heading_angle, got.cardinal);
      end
    end else begin
      want = headings_due.pop_front();
      if (got.x_field !== want.x_field || got.y_field !== want.y_field ||
          got.z_field !== want.z_field || got.heading_angle !== want.heading_angle ||
          got.cardinal !== want.cardinal) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("result word %0d: expected x=%0d y=%0d z=%0d heading=%0d cardinal=%0d",
                   words_seen, want.x_field, want.y_field, want.z_field,
                   want.heading_angle, want.cardinal);
          $display("result word %0d: actual   x=%0d y=%0d z=%0d heading=%0d cardinal=%0d",
                   words_seen, got.x_field, got.y_field, got.z_field,
                   got.heading_angle, got.cardinal);
        end
      end
    end
  endtask

  initial begin
    clk = 1'b0;
    forever begin
      #4 clk = ~clk;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      sample_ch.valid <= 1'b0;
      sample_ch.data <= '0;
    end else begin
      if (sample_ch.valid && sample_ch.ready) begin
        headings_due.push_back(compass_of(sample_ch.data));
      end
      if (!sample_ch.valid || sample_ch.ready) begin
        if (readings_pending.size() > 0 &&
            ((words_sent >= 600 && words_sent < 900) || $urandom_range(99) >= 34)) begin
          sample_ch.data <= readings_pending.pop_front();
          sample_ch.valid <= 1'b1;
          words_sent++;
        end else begin
          sample_ch.valid <= 1'b0;
        end
      end
    end
  end

  // The long hold-off lets the pipeline fill up and stall the sample side.
  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
      hold_left = 0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        check_word(result_ch.data);
        words_seen++;
        if (words_seen == 1100) begin
          hold_left = 150;
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= (words_seen >= 600 && words_seen < 900) ||
                           $urandom_range(99) >= 34;
      end
    end
  end

  initial begin
    int x;
    int y;
    int z;
    int mode;
    int total_words;
    in_word_t raw;
    sample_ch.valid = 1'b0;
    sample_ch.data = '0;
    result_ch.ready = 1'b0;
    words_sent = 0;
    words_seen = 0;
    mismatches = 0;
    rst = 1'b1;

    readings_pending.push_back(reading(0, 0, 0));
    readings_pending.push_back(reading(1000, 0, 32767));
    readings_pending.push_back(reading(-1000, 0, -32768));
    readings_pending.push_back(reading(0, 1000, -1));
    readings_pending.push_back(reading(0, -1000, 1));
    readings_pending.push_back(reading(32767, 32767, 0));
    readings_pending.push_back(reading(-32768, -32768, 0));
    readings_pending.push_back(reading(32767, -32768, 5));
    readings_pending.push_back(reading(-32768, 32767, -5));
    readings_pending.push_back(reading(32767, -1, 100));
    readings_pending.push_back(reading(32767, 1, -100));
    readings_pending.push_back(reading(-32768, -1, 0));
    readings_pending.push_back(reading(-32768, 1, 0));
    readings_pending.push_back(reading(1, -1, 0));
    readings_pending.push_back(reading(-1, 1, 0));
    readings_pending.push_back(reading(1, 1, 0));
    readings_pending.push_back(reading(-1, -1, 0));
    readings_pending.push_back(reading(-32768, 0, 32767));
    readings_pending.push_back(reading(0, -32768, -32768));
    readings_pending.push_back(reading(0, 32767, 32767));
    readings_pending.push_back(reading(-1, -1, -1));
    readings_pending.push_back(reading(500, -500, 7));
    readings_pending.push_back(reading(-500, 500, 7));

    for (int n = 0; n < RANDOM_READINGS; n++) begin
      mode = $urandom_range(9);
      z = $urandom_range(65535);
      if (mode <= 5) begin
        raw = 48'({$urandom(), $urandom()});
        readings_pending.push_back(raw);
      end else begin
        if (mode <= 7) begin
          x = int'($urandom_range(16)) - 8;
          y = int'($urandom_range(16)) - 8;
        end else if (mode == 8) begin
          x = $urandom_range(65535);
          y = 0;
          if ($urandom_range(1) == 1) begin
            y = x;
            x = 0;
          end
        end else begin
          x = int'($urandom_range(65535)) - 32768;
          y = ($urandom_range(1) == 1) ? x : -x;
        end
        readings_pending.push_back(reading(x, y, z));
      end
    end
    total_words = readings_pending.size();

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    while (words_seen < total_words) begin
      @(posedge clk);
    end
    repeat (STEPS + 10) @(posedge clk);
    if (mismatches == 0 && headings_due.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #2400000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
